// ===== design/toia_pkg.sv =====
// ----------------------------------------------------------------------------
// toia_pkg
// Types and constants shared by the tracked object id allocator.
// ----------------------------------------------------------------------------
package toia_pkg;

	localparam int SHORT_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ABSENCE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PED_KEEP_MS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATERAL_LIMIT = 3'd3;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_OBSERVE = 1'b1;

	localparam logic [7:0] TYPE_PEDESTRIAN = 8'd1;
	localparam logic [4:0] ABSENCE_MAX = 5'd31;

	typedef struct packed {
		logic        mode;
		logic [31:0] frame_time_ms;
		logic [31:0] track_id;
		logic [15:0] confidence;
		logic signed [15:0] lateral_cm;
		logic [7:0]  object_type;
	} item_t;

	typedef struct packed {
		logic [7:0] short_id;
		logic       newly_assigned;
		logic       accepted;
		logic [7:0] released_count;
	} result_t;

	typedef struct packed {
		logic [4:0]  absence_limit;
		logic [15:0] pedestrian_keep_ms;
		logic [15:0] confidence_threshold;
		logic [14:0] lateral_limit_cm;
	} cfg_t;

	typedef struct packed {
		logic [31:0] tracker;
		logic [4:0]  absence;
		logic        has_state;
		logic        pedestrian;
		logic [31:0] last_seen_ms;
	} entry_t;

	typedef struct packed {
		logic   match;
		logic   expire;
		entry_t aged;
	} eval_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_FINISH = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

endpackage

// ===== design/tracked_object_id_allocator.sv =====
// ----------------------------------------------------------------------------
// tracked_object_id_allocator
// Binds 32-bit tracker ids to short ids 1..MAX_SHORT_ID and ages them per frame.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  item     | in        | item_valid / item_ready     | item_t
//  result   | out       | result_valid / result_ready | result_t
//  config   | in        | cfg_we                      | cfg_idx, cfg_wdata
//
// Every item except a rejected observation scans the entry table once, one
// entry per cycle through the shared entry unit and the entry RAM read port:
// then through ST_FINISH to ST_DONE, which registers the result; a rejected
// observation goes from accept straight to ST_DONE. item_ready is high only
// while idle. A stalled result holds the block in its last state. Reset
// clears the valid bits at once; no clearing pass.
module tracked_object_id_allocator import toia_pkg::*; #(
	parameter int MAX_SHORT_ID = 254
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	localparam int IDX_W = (MAX_SHORT_ID > 1) ? $clog2(MAX_SHORT_ID) : 1;
	localparam int CNT_W = $clog2(MAX_SHORT_ID + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_SHORT_ID);

	state_t state_q;
	cfg_t cfg_q;
	item_t item_q;
	result_t pend_q;
	logic [MAX_SHORT_ID-1:0] valid_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [IDX_W-1:0] idx_s1;
	logic vld_s1;
	logic found_q, free_q;
	logic [IDX_W-1:0] hit_slot_q, free_slot_q;
	entry_t hit_entry_q;
	logic [SHORT_W-1:0] rel_q;

	logic re;
	logic we;
	logic [IDX_W-1:0] waddr;
	entry_t wdata, rdata, fin_entry;
	eval_t ev;
	logic cur_valid;
	logic [16:0] lat_abs;
	logic lat_ok;
	logic [IDX_W-1:0] fin_slot;

	assign item_ready = (state_q == ST_IDLE);
	assign re = (state_q == ST_SCAN) && (rd_cnt_q != LAST_CNT);
	assign cur_valid = valid_q[idx_s1];

	toia_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SHORT_ID), .AW(IDX_W)) u_ram (
		.clk, .we, .waddr, .wdata, .re,
		.raddr(rd_cnt_q[IDX_W-1:0]), .rdata
	);

	toia_entry_unit u_unit (.entry(rdata), .item(item_q), .cfg(cfg_q), .result(ev));

	always_comb begin
		lat_abs = item_q.lateral_cm[15] ? 17'h10000 - {1'b0, item_q.lateral_cm}
			: {1'b0, item_q.lateral_cm};
		lat_ok = lat_abs <= {2'b00, cfg_q.lateral_limit_cm};
		fin_slot = found_q ? hit_slot_q : free_slot_q;
		if (found_q) begin
			fin_entry = hit_entry_q;
		end else begin
			fin_entry = '0;
			fin_entry.tracker = item_q.track_id;
		end
		fin_entry.absence = '0;
		if (lat_ok) begin
			fin_entry.has_state = 1'b1;
			fin_entry.pedestrian = (item_q.object_type == TYPE_PEDESTRIAN);
			fin_entry.last_seen_ms = item_q.frame_time_ms;
		end
		if (state_q == ST_FINISH) begin
			we = (item_q.mode == MODE_OBSERVE) && (found_q || free_q);
			waddr = fin_slot;
			wdata = fin_entry;
		end else begin
			we = (state_q == ST_SCAN) && vld_s1 && (item_q.mode == MODE_TICK) && cur_valid;
			waddr = idx_s1;
			wdata = ev.aged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{absence_limit: 5'd20, pedestrian_keep_ms: 16'd2000,
				confidence_threshold: 16'd58982, lateral_limit_cm: 15'd500};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ABSENCE_LIMIT:  cfg_q.absence_limit <= cfg_wdata[4:0];
				REG_PED_KEEP_MS:    cfg_q.pedestrian_keep_ms <= cfg_wdata;
				REG_CONF_THRESHOLD: cfg_q.confidence_threshold <= cfg_wdata;
				REG_LATERAL_LIMIT:  cfg_q.lateral_limit_cm <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (state_q == ST_SCAN && vld_s1 && cur_valid && ev.match && !found_q) begin
			hit_slot_q <= idx_s1;
			hit_entry_q <= rdata;
		end
		if (state_q == ST_SCAN && vld_s1 && !cur_valid && !free_q) begin
			free_slot_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			rd_cnt_q <= '0;
			idx_s1 <= '0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			rel_q <= '0;
			pend_q <= '0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			vld_s1 <= re;
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						rd_cnt_q <= '0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						rel_q <= '0;
						pend_q <= '0;
						if (item.mode == MODE_OBSERVE &&
							item.confidence <= cfg_q.confidence_threshold) begin
							// drop: no table access
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (re) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (vld_s1) begin
						if (item_q.mode == MODE_TICK) begin
							if (cur_valid && ev.expire) begin
								valid_q[idx_s1] <= 1'b0;
								rel_q <= rel_q + SHORT_W'(1);
							end
						end else begin
							if (cur_valid && ev.match) begin
								found_q <= 1'b1;
							end
							if (!cur_valid) begin
								free_q <= 1'b1;
							end
						end
					end else if (!re) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (item_q.mode == MODE_TICK) begin
						pend_q.released_count <= rel_q;
					end else begin
						pend_q.accepted <= 1'b1;
						if (found_q || free_q) begin
							valid_q[fin_slot] <= 1'b1;
							pend_q.short_id <= SHORT_W'(fin_slot) + SHORT_W'(1);
							pend_q.newly_assigned <= !found_q;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!result_valid || result_ready) begin
						result <= pend_q;
						result_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/toia_ram.sv =====
// ----------------------------------------------------------------------------
// toia_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module toia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/toia_entry_unit.sv =====
// ----------------------------------------------------------------------------
// toia_entry_unit
// Shared per-entry evaluator: tracker match, aging and expiry of one entry.
// ----------------------------------------------------------------------------
module toia_entry_unit import toia_pkg::*; (
	input  entry_t entry,
	input  item_t  item,
	input  cfg_t   cfg,
	output eval_t  result
);
	logic [31:0] age_ms;
	logic [4:0]  absence_next;

	always_comb begin
		age_ms = item.frame_time_ms - entry.last_seen_ms;
		absence_next = (entry.absence < ABSENCE_MAX) ? entry.absence + 5'd1 : entry.absence;
		result.match = (entry.tracker == item.track_id);
		result.aged = entry;
		result.aged.absence = absence_next;
		if (entry.has_state && entry.pedestrian) begin
			result.expire = age_ms > {16'd0, cfg.pedestrian_keep_ms};
		end else begin
			result.expire = absence_next >= cfg.absence_limit;
		end
	end
endmodule

// ===== design/toia_checker.sv =====
// ----------------------------------------------------------------------------
// toia_checker
// Port-level checks of the tracked object id allocator.
// ----------------------------------------------------------------------------
module toia_checker import toia_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);
	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.accepted |-> result.short_id == 8'd0 && !result.newly_assigned)
		else $error("rejected item carries an id");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.newly_assigned |-> result.accepted && result.short_id != 8'd0)
		else $error("new id without acceptance");

	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.released_count != 8'd0 |-> !result.accepted &&
		result.short_id == 8'd0)
		else $error("release count on observe item");

	// no item taken while the previous one is still in work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready right after accept");
endmodule

bind tracked_object_id_allocator toia_checker u_toia_checker (
	.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_ready(item_ready),
	.result_valid(result_valid), .result_ready(result_ready), .result(result)
);

// ===== sim/tracked_object_id_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracked_object_id_allocator_tb
// Drives tick and observe items through the allocator and checks each result
// against a cycle-free model of the id table, aging and release rules. Runs
// several register settings, fills the table, and stalls the result side.
// ----------------------------------------------------------------------------
module tracked_object_id_allocator_tb;
	import toia_pkg::*;

	localparam int NUM_IDS = 254;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	item_t                 item;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tracked_object_id_allocator #(.MAX_SHORT_ID(NUM_IDS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// shadow of the id table and the registers
	bit          id_valid [NUM_IDS];
	logic [31:0] id_tracker [NUM_IDS];
	logic [4:0]  id_absence [NUM_IDS];
	bit          id_has_state [NUM_IDS];
	bit          id_ped [NUM_IDS];
	logic [31:0] id_seen [NUM_IDS];
	logic [4:0]  absence_limit;
	logic [15:0] ped_keep_ms;
	logic [15:0] conf_threshold;
	logic [14:0] lateral_limit;

	item_t   pending_items[$];
	result_t expected_results[$];
	int      mismatches;
	bit      item_taken;
	bit      result_taken;
	int      send_gap;
	int      recv_stall;
	int      recv_holdoff;

	logic [31:0] now_ms;
	logic [31:0] tracker_pool [40];

	always #5 clk = ~clk;

	function automatic void queue_item(item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic result_t allocate_or_age(item_t it);
		result_t r;
		int slot;
		bit expire;
		logic [16:0] lat_abs;
		r = '0;
		if (it.mode == MODE_TICK) begin
			for (int i = 0; i < NUM_IDS; i++) begin
				if (id_valid[i]) begin
					if (id_absence[i] != ABSENCE_MAX)
						id_absence[i] = id_absence[i] + 5'd1;
					if (id_has_state[i] && id_ped[i])
						expire = (it.frame_time_ms - id_seen[i]) > {16'd0, ped_keep_ms};
					else
						expire = id_absence[i] >= absence_limit;
					if (expire) begin
						id_valid[i] = 0;
						r.released_count = r.released_count + 8'd1;
					end
				end
			end
			return r;
		end
		if (it.confidence <= conf_threshold)
			return r;
		r.accepted = 1'b1;
		slot = -1;
		for (int i = 0; i < NUM_IDS && slot < 0; i++)
			if (id_valid[i] && id_tracker[i] == it.track_id)
				slot = i;
		if (slot < 0) begin
			for (int i = 0; i < NUM_IDS && slot < 0; i++)
				if (!id_valid[i])
					slot = i;
			if (slot < 0)
				return r;
			id_valid[slot] = 1;
			id_tracker[slot] = it.track_id;
			id_has_state[slot] = 0;
			id_ped[slot] = 0;
			id_seen[slot] = '0;
			r.newly_assigned = 1'b1;
		end
		id_absence[slot] = '0;
		r.short_id = 8'(slot + 1);
		lat_abs = it.lateral_cm[15] ? 17'h10000 - {1'b0, it.lateral_cm} : {1'b0, it.lateral_cm};
		if (lat_abs <= {2'b0, lateral_limit}) begin
			id_has_state[slot] = 1;
			id_ped[slot] = (it.object_type == TYPE_PEDESTRIAN);
			id_seen[slot] = it.frame_time_ms;
		end
		return r;
	endfunction

	// sample both handshakes at the rising edge
	always @(posedge clk) begin
		result_t exp_r;
		item_taken = item_valid && item_ready;
		result_taken = result_valid && result_ready;
		if (item_taken)
			expected_results.insert(expected_results.size(), allocate_or_age(item));
		if (result_taken) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: %h", result);
				mismatches++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.short_id !== exp_r.short_id) begin
					$error("short_id expected %0d got %0d", exp_r.short_id, result.short_id);
					mismatches++;
				end
				if (result.newly_assigned !== exp_r.newly_assigned) begin
					$error("newly_assigned expected %0b got %0b",
						exp_r.newly_assigned, result.newly_assigned);
					mismatches++;
				end
				if (result.accepted !== exp_r.accepted) begin
					$error("accepted expected %0b got %0b", exp_r.accepted, result.accepted);
					mismatches++;
				end
				if (result.released_count !== exp_r.released_count) begin
					$error("released_count expected %0d got %0d",
						exp_r.released_count, result.released_count);
					mismatches++;
				end
			end
		end
	end

	// item driver
	always @(negedge clk) begin
		logic  next_valid;
		item_t next_item;
		next_valid = item_valid;
		next_item = item;
		if (!item_valid || item_taken) begin
			if (item_taken) begin
				item_taken = 0;
				send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			end
			next_valid = 1'b0;
			if (send_gap > 0)
				send_gap--;
			else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				next_valid = 1'b1;
			end
		end
		item_valid <= next_valid;
		item <= next_item;
	end

	// result receiver
	always @(negedge clk) begin
		if (result_taken) begin
			result_taken = 0;
			recv_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		end
		if (recv_holdoff > 0) begin
			recv_holdoff--;
			result_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			result_ready <= 1'b0;
		end else
			result_ready <= 1'b1;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		case (idx)
			REG_ABSENCE_LIMIT:  absence_limit = data[4:0];
			REG_PED_KEEP_MS:    ped_keep_ms = data;
			REG_CONF_THRESHOLD: conf_threshold = data;
			REG_LATERAL_LIMIT:  lateral_limit = data[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// check at clock edges only, so an item popped but not yet driven still counts
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic item_t tick_item();
		item_t it;
		it = '0;
		it.mode = MODE_TICK;
		now_ms = now_ms + $urandom_range(20, 400);
		it.frame_time_ms = now_ms;
		it.track_id = $urandom;
		return it;
	endfunction

	function automatic item_t observe_item(logic [31:0] tid, logic [15:0] conf,
			logic [15:0] lat, logic [7:0] otype);
		item_t it;
		it.mode = MODE_OBSERVE;
		it.frame_time_ms = now_ms;
		it.track_id = tid;
		it.confidence = conf;
		it.lateral_cm = lat;
		it.object_type = otype;
		return it;
	endfunction

	function automatic item_t random_item(int pool_n);
		item_t it;
		int sel;
		logic [15:0] conf, lat;
		logic [16:0] span;
		sel = $urandom_range(0, 99);
		if (sel < 15)
			return tick_item();
		if (sel < 20) begin
			it = {$urandom, $urandom, $urandom, 9'($urandom)};
			return it;
		end
		if (conf_threshold != 16'hFFFF && $urandom_range(0, 4) != 0)
			conf = conf_threshold + 16'(1 + $urandom_range(0, 65534 - conf_threshold));
		else
			conf = $urandom;
		span = {2'b0, lateral_limit};
		if ($urandom_range(0, 9) < 7)
			lat = $urandom_range(0, 1) ? 16'(span - $urandom_range(0, span))
				: 16'(-$signed({1'b0, 16'($urandom_range(0, span))}));
		else
			lat = $urandom;
		return observe_item(tracker_pool[$urandom_range(0, pool_n - 1)], conf, lat,
			$urandom_range(0, 1) ? TYPE_PEDESTRIAN : 8'($urandom));
	endfunction

	task automatic random_phase(int count, int pool_n);
		for (int i = 0; i < pool_n; i++)
			tracker_pool[i] = $urandom;
		for (int i = 0; i < count; i++)
			queue_item(random_item(pool_n));
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		item_valid = 0;
		item = '0;
		result_ready = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_wdata = '0;
		item_taken = 0;
		result_taken = 0;
		send_gap = 0;
		recv_stall = 0;
		recv_holdoff = 0;
		mismatches = 0;
		now_ms = 32'd1000;
		absence_limit = 5'd20;
		ped_keep_ms = 16'd2000;
		conf_threshold = 16'd58982;
		lateral_limit = 15'd500;
		for (int i = 0; i < NUM_IDS; i++) begin
			id_valid[i] = 0;
			id_tracker[i] = '0;
			id_absence[i] = '0;
			id_has_state[i] = 0;
			id_ped[i] = 0;
			id_seen[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset settings, threshold edges, lateral edges, reuse, aging
		queue_item(tick_item());
		queue_item(observe_item(32'h0, 16'd0, 16'd0, 8'd1));
		queue_item(observe_item(32'h1, 16'd58982, 16'd0, 8'd1));
		queue_item(observe_item(32'h0, 16'd58983, 16'd500, 8'd1));
		queue_item(observe_item(32'hFFFF_FFFF, 16'hFFFF, -16'sd500, 8'd0));
		queue_item(observe_item(32'h1234_5678, 16'hFFFF, 16'd501, 8'd1));
		queue_item(observe_item(32'hDEAD_BEEF, 16'hFFFF, 16'h8000, 8'd1));
		queue_item(observe_item(32'hA5A5_5A5A, 16'hFFFF, 16'h7FFF, 8'd255));
		queue_item(observe_item(32'h0, 16'hF000, -16'sd501, 8'd0));
		queue_item(observe_item(32'hFFFF_FFFF, 16'hF000, 16'd10, 8'd1));
		queue_item(tick_item());
		now_ms = now_ms + 32'd1900;
		queue_item(tick_item());
		queue_item(observe_item(32'h5555_AAAA, 16'hFFFF, -16'sd1, 8'd2));
		for (int i = 0; i < 5; i++)
			queue_item(tick_item());
		wait_drained();

		// short aging, full lateral range; long result hold-off fills the block
		write_reg(REG_ABSENCE_LIMIT, 16'd3);
		write_reg(REG_PED_KEEP_MS, 16'd150);
		write_reg(REG_CONF_THRESHOLD, 16'h8000);
		write_reg(REG_LATERAL_LIMIT, 16'h7FFF);
		random_phase(300, 30);
		recv_holdoff = 2000;
		wait_drained();

		// fill the table beyond its size; extremes of every register
		write_reg(REG_ABSENCE_LIMIT, 16'hFFFF);
		write_reg(REG_PED_KEEP_MS, 16'hFFFF);
		write_reg(REG_CONF_THRESHOLD, 16'h0000);
		write_reg(REG_LATERAL_LIMIT, 16'h0000);
		for (int i = 0; i < 270; i++)
			queue_item(observe_item($urandom, 16'($urandom_range(1, 65535)),
				($urandom_range(0, 1) ? 16'd0 : 16'($urandom)), 8'($urandom_range(0, 2))));
		queue_item(observe_item(32'hFFFF_FFFF, 16'd0, 16'd0, 8'd1));
		queue_item(tick_item());
		wait_drained();

		// absence limit masked to zero, everything rejected, junk index ignored
		write_reg(REG_ABSENCE_LIMIT, 16'h0020);
		write_reg(REG_PED_KEEP_MS, 16'h0000);
		write_reg(REG_CONF_THRESHOLD, 16'hFFFF);
		write_reg(REG_LATERAL_LIMIT, 16'h83E8);
		write_reg(3'd5, 16'h0001);
		random_phase(30, 20);
		queue_item(tick_item());
		queue_item(tick_item());
		wait_drained();

		// reset settings again but for an absence limit of 5, frame time wrapping through zero
		write_reg(REG_ABSENCE_LIMIT, 16'd5);
		write_reg(REG_PED_KEEP_MS, 16'd2000);
		write_reg(REG_CONF_THRESHOLD, 16'd58982);
		write_reg(REG_LATERAL_LIMIT, 16'd500);
		now_ms = 32'hFFFF_F000;
		random_phase(500, 40);
		wait_drained();

		write_reg(REG_ABSENCE_LIMIT, 16'd1);
		write_reg(REG_PED_KEEP_MS, 16'd300);
		write_reg(REG_CONF_THRESHOLD, 16'd1000);
		write_reg(REG_LATERAL_LIMIT, 16'd2000);
		random_phase(120, 12);
		wait_drained();
		repeat (300) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
